// ===== hw/rtl/rotation_matrix_to_euler_macros.svh =====
// Assertion macros for the rotation matrix to Euler angles block.
// Used by files that expect clk_i and rst_ni in scope.
`ifndef ROTATION_MATRIX_TO_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_MACROS_SVH

// implication checked every clock, off during reset
`define RME_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rme assertion failed");

// plain condition checked every clock, also during reset
`define RME_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rme assertion failed");

`endif

// ===== hw/rtl/rme_pkg.sv =====
// Package for the rotation matrix to Euler angles block.
// Widths, register indexes, CORDIC table and angle quantizing; no dependencies.
package rme_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int SQ_STEPS     = 15;  // isqrt digit steps for a 29-bit radicand
  localparam int CW           = 34;  // CORDIC datapath width
  localparam int OW           = 17;  // CORDIC operand width (negated Q1.14)
  localparam int RW           = 30;  // isqrt working width

  localparam int QSHIFT = 32 - ANGLE_BITS;
  localparam int SH_R   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SH_L   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  localparam logic signed [CW-1:0] HALF_PI = CW'(64'sd1073741824);
  localparam logic signed [15:0]   ONE_Q14 = 16'sd16384;

  typedef enum logic [7:0] {
    REG_GIMBAL_EN  = 8'd0,
    REG_GIMBAL_THR = 8'd1
  } cfg_reg_e;

  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = CW'(64'sd536870912);
      5'd1:  v = CW'(64'sd316933406);
      5'd2:  v = CW'(64'sd167458907);
      5'd3:  v = CW'(64'sd85004756);
      5'd4:  v = CW'(64'sd42667331);
      5'd5:  v = CW'(64'sd21354465);
      5'd6:  v = CW'(64'sd10679838);
      5'd7:  v = CW'(64'sd5340245);
      5'd8:  v = CW'(64'sd2670163);
      5'd9:  v = CW'(64'sd1335087);
      5'd10: v = CW'(64'sd667544);
      5'd11: v = CW'(64'sd333772);
      5'd12: v = CW'(64'sd166886);
      5'd13: v = CW'(64'sd83443);
      5'd14: v = CW'(64'sd41722);
      5'd15: v = CW'(64'sd20861);
      5'd16: v = CW'(64'sd10430);
      5'd17: v = CW'(64'sd5215);
      5'd18: v = CW'(64'sd2608);
      5'd19: v = CW'(64'sd1304);
      5'd20: v = CW'(64'sd652);
      5'd21: v = CW'(64'sd326);
      5'd22: v = CW'(64'sd163);
      5'd23: v = CW'(64'sd81);
      default: v = '0;
    endcase
    return v;
  endfunction

  // internal angle (pi = 2^31) to 16-bit binary angle, round half up
  function automatic logic [15:0] to_out(input logic signed [CW-1:0] z);
    logic signed [CW-1:0] q;
    q = (z + CW'(64'sd1 <<< (QSHIFT - 1))) >>> QSHIFT;
    q = (q >>> SH_R) <<< SH_L;
    return q[15:0];
  endfunction

endpackage

// ===== hw/rtl/rme_if.sv =====
// Stream and configuration interfaces of the rotation matrix to Euler block.
// Depends on nothing.
interface rme_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m22, output ready);
endinterface

interface rme_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] angle_x, angle_y, angle_z;
  logic              gimbal_lock;
  modport source (output valid, angle_x, angle_y, angle_z, gimbal_lock, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, gimbal_lock, output ready);
endinterface

interface rme_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rme_isqrt.sv =====
// Pipelined integer square root, one result digit per register stage.
// Depends on rme_pkg.
module rme_isqrt
  import rme_pkg::*;
(
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] n_i,
  output logic [14:0]   r_o
);

  logic [RW-1:0] n_q [SQ_STEPS+1];
  logic [RW-1:0] r_q [SQ_STEPS+1];

  assign n_q[0] = n_i;
  assign r_q[0] = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [RW-1:0] trial;
    logic [RW-1:0] n_d, r_d;
    always_comb begin
      trial = r_q[k] + BIT;
      if (n_q[k] >= trial) begin
        n_d = n_q[k] - trial;
        r_d = (r_q[k] >> 1) + BIT;
      end else begin
        n_d = n_q[k];
        r_d = r_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1] <= n_d;
        r_q[k+1] <= r_d;
      end
    end
  end

  assign r_o = r_q[SQ_STEPS][14:0];

endmodule

// ===== hw/rtl/rme_cordic.sv =====
// Pipelined CORDIC atan2 in vectoring mode, quadrant pre-rotation first.
// Depends on rme_pkg.
module rme_cordic
  import rme_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [OW-1:0] y_i,
  input  logic signed [OW-1:0] x_i,
  output logic signed [CW-1:0] z_o
);

  logic signed [CW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] z_q [CORDIC_STEPS+1];
  logic                 zero_q [CORDIC_STEPS+1];

  logic signed [CW-1:0] xs, ys, x0_d, y0_d, z0_d;

  always_comb begin
    xs = CW'(x_i) <<< 14;
    ys = CW'(y_i) <<< 14;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0_d = ys;
        y0_d = -xs;
        z0_d = HALF_PI;
      end else begin
        x0_d = -ys;
        y0_d = xs;
        z0_d = -HALF_PI;
      end
    end else begin
      x0_d = xs;
      y0_d = ys;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      z_q[0]    <= z0_d;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_lut(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_lut(5'(i));
        end
      end
    end
  end

  assign z_o = zero_q[CORDIC_STEPS] ? '0 : z_q[CORDIC_STEPS];

endmodule

// ===== hw/rtl/rotation_matrix_to_euler.sv =====
// Rotation matrix to Euler angles, top level.
// Channels in_if (matrix entries, Q1.14), out_if (angles, 32768 = pi) and
// cfg_if (register writes: index 0 gimbal check enable, 1 gimbal threshold).
// A request is taken when valid and ready are high at a clock edge.
// The pipeline has one input stage, fifteen isqrt digit stages, the
// CORDIC pre-rotation and iteration stages, a quantizing stage and the
// output register. Throughput is one matrix per cycle while the receiver
// does not stall; four CORDIC pipelines run side by side (asin, X pair,
// Z pair, gimbal Z pair) and the result is picked at the end.
// When the receiver stalls the whole pipeline holds and in_if.ready drops;
// nothing is lost or repeated. Reset empties the pipeline and loads the
// registers with enable 1 and threshold 52. The user must write configuration
// only while the block is idle; the block does not enforce this.
// cfg_if.ready is always high, unknown indexes are ignored.
// Depends on rme_pkg, rme_if, rme_isqrt, rme_cordic and the macro header.
`include "rotation_matrix_to_euler_macros.svh"

module rotation_matrix_to_euler
  import rme_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rme_in_if.sink    in_if,
  rme_out_if.source out_if,
  rme_cfg_if.sink   cfg_if
);

  localparam int DEPTH = 1 + SQ_STEPS + 1 + CORDIC_STEPS + 1;

  typedef struct packed {
    logic signed [15:0] m00, m01, m10, m11, m12, m22;
    logic signed [15:0] s;  // saturated m02
  } carry_t;

  logic        adv;
  logic        in_acc;
  logic [DEPTH-1:0] vld_q;
  logic        en_q, en_d;
  logic [14:0] thr_q, thr_d;

  // configuration
  assign cfg_if.ready = 1'b1;
  always_comb begin
    en_d  = en_q;
    thr_d = thr_q;
    if (cfg_if.valid) begin
      unique case (cfg_reg_e'(cfg_if.index))
        REG_GIMBAL_EN:  en_d  = cfg_if.data[0];
        REG_GIMBAL_THR: thr_d = cfg_if.data[14:0];
        default: ;
      endcase
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b1;
      thr_q <= 15'd52;
    end else begin
      en_q  <= en_d;
      thr_q <= thr_d;
    end
  end

  // pipeline control
  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;
  assign in_acc      = in_if.valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_if.valid};
    end
  end

  // input stage: saturate m02, form radicand
  carry_t        c_d;
  carry_t        c_q [SQ_STEPS+1];
  logic [RW-1:0] n_q;
  logic signed [31:0] sq;

  always_comb begin
    c_d = '{m00: in_if.m00, m01: in_if.m01, m10: in_if.m10, m11: in_if.m11,
            m12: in_if.m12, m22: in_if.m22, s: in_if.m02};
    if (in_if.m02 > ONE_Q14) c_d.s = ONE_Q14;
    if (in_if.m02 < -ONE_Q14) c_d.s = -ONE_Q14;
    sq = c_d.s * c_d.s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= c_d;
      n_q    <= RW'(32'sd268435456 - sq);
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (adv) c_q[k+1] <= c_q[k];
    end
  end

  logic [14:0] cos_c;
  rme_isqrt u_isqrt (
    .clk_i (clk_i),
    .en_i  (adv),
    .n_i   (n_q),
    .r_o   (cos_c)
  );

  carry_t cc;
  assign cc = c_q[SQ_STEPS];

  logic signed [CW-1:0] zy, zx, zz, zg;

  rme_cordic u_cordic_y (
    .clk_i (clk_i), .en_i (adv),
    .y_i   (OW'(cc.s)), .x_i ($signed({2'b00, cos_c})), .z_o (zy)
  );
  rme_cordic u_cordic_x (
    .clk_i (clk_i), .en_i (adv),
    .y_i   (-OW'(cc.m12)), .x_i (OW'(cc.m22)), .z_o (zx)
  );
  rme_cordic u_cordic_z (
    .clk_i (clk_i), .en_i (adv),
    .y_i   (-OW'(cc.m01)), .x_i (OW'(cc.m00)), .z_o (zz)
  );
  rme_cordic u_cordic_g (
    .clk_i (clk_i), .en_i (adv),
    .y_i   (OW'(cc.m10)), .x_i (OW'(cc.m11)), .z_o (zg)
  );

  // quantizing stage
  logic [15:0] ay_q, ax_q, az_q, ag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ay_q <= to_out(-zy);
      ax_q <= to_out(zx);
      az_q <= to_out(zz);
      ag_q <= to_out(zg);
    end
  end

  // gimbal decision and output register
  logic [16:0] ymag;
  logic        gim;
  assign ymag = ay_q[15] ? 17'(-$signed({ay_q[15], ay_q})) : {1'b0, ay_q};
  assign gim  = en_q && (ymag < {2'b00, thr_q});

  logic        ovld_q;
  logic [15:0] ox_q, oy_q, oz_q;
  logic        og_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (adv) begin
      ovld_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oy_q <= ay_q;
      og_q <= gim;
      ox_q <= gim ? 16'd0 : ax_q;
      oz_q <= gim ? ag_q : az_q;
    end
  end

  assign out_if.valid       = ovld_q;
  assign out_if.angle_x     = ox_q;
  assign out_if.angle_y     = oy_q;
  assign out_if.angle_z     = oz_q;
  assign out_if.gimbal_lock = og_q;

  `RME_ASSERT(a_gimbal_x_zero, out_if.valid && out_if.gimbal_lock |-> out_if.angle_x == 16'd0)
  `RME_ASSERT(a_accept_enters, in_acc |=> vld_q[0])
  `RME_ASSERT(a_stall_holds, out_if.valid && !out_if.ready |=> out_if.valid && $stable(vld_q))
  `RME_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_if.valid && vld_q == '0)

endmodule
